// ===== design/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/i2cdw_pkg.sv =====
package i2cdw_pkg;

  localparam int unsigned StepW = 7;

  localparam logic [StepW-1:0] LastStep   = 7'd88;
  localparam logic [StepW-1:0] StartSteps = 7'd4;
  localparam logic [StepW-1:0] ByteSteps  = 7'd27;
  localparam logic [StepW-1:0] StopFirst  = 7'd85;

  localparam logic [7:0] CtrlCmd   = 8'h00;
  localparam logic [7:0] CtrlData  = 8'h40;
  localparam logic [7:0] AddrReset = 8'h78;

  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SEND = 1'b1
  } action_t;

  typedef struct packed {
    logic scl;
    logic sda;
  } lines_t;

  typedef struct packed {
    logic refused;
    logic done;
    logic busy;
    logic sda;
    logic scl;
  } result_t;

endpackage

// ===== design/i2cdw_step.sv =====
module i2cdw_step (
  input  logic [i2cdw_pkg::StepW-1:0] step,
  input  logic [7:0]                  address_byte,
  input  logic                        held_is_data,
  input  logic [7:0]                  held_payload,
  input  i2cdw_pkg::lines_t           lines_cur,
  output i2cdw_pkg::lines_t           lines_nxt
);

  logic [i2cdw_pkg::StepW-1:0] t;
  logic [i2cdw_pkg::StepW-1:0] r_full;
  logic [4:0]                  r;
  logic [1:0]                  byte_sel;
  logic [9:0]                  r_mul;
  logic [2:0]                  bit_pos;
  logic [4:0]                  bit_x3;
  logic [1:0]                  phase;
  logic [7:0]                  cur_byte;
  logic [1:0]                  stop_ph;

  always_comb begin
    t = step - i2cdw_pkg::StartSteps;
    if (t >= 7'(2 * i2cdw_pkg::ByteSteps)) begin
      byte_sel = 2'd2;
      r_full   = t - 7'(2 * i2cdw_pkg::ByteSteps);
    end else if (t >= i2cdw_pkg::ByteSteps) begin
      byte_sel = 2'd1;
      r_full   = t - i2cdw_pkg::ByteSteps;
    end else begin
      byte_sel = 2'd0;
      r_full   = t;
    end
    r       = r_full[4:0];
    r_mul   = 10'(r) * 10'd11;
    bit_pos = r_mul[7:5];
    bit_x3  = {1'b0, bit_pos, 1'b0} + {2'b00, bit_pos};
    phase   = 2'(r - bit_x3);

    case (byte_sel)
      2'd0:    cur_byte = address_byte;
      2'd1:    cur_byte = held_is_data ? i2cdw_pkg::CtrlData : i2cdw_pkg::CtrlCmd;
      default: cur_byte = held_payload;
    endcase

    stop_ph   = 2'(step - i2cdw_pkg::StopFirst);
    lines_nxt = lines_cur;

    if (step < i2cdw_pkg::StartSteps) begin
      case (step[1:0])
        2'd0:    lines_nxt.scl = 1'b1;
        2'd1:    lines_nxt.sda = 1'b1;
        2'd2:    lines_nxt.sda = 1'b0;
        default: lines_nxt.scl = 1'b0;
      endcase
    end else if (step < i2cdw_pkg::StopFirst) begin
      if (r < 5'd24) begin
        case (phase)
          2'd0:    lines_nxt.sda = cur_byte[3'd7 - bit_pos];
          2'd1:    lines_nxt.scl = 1'b1;
          default: lines_nxt.scl = 1'b0;
        endcase
      end else if (r == 5'd24) begin
        lines_nxt.sda = 1'b1;
      end else if (r == 5'd25) begin
        lines_nxt.scl = 1'b1;
      end else begin
        lines_nxt.scl = 1'b0;
      end
    end else begin
      case (stop_ph)
        2'd0:    lines_nxt.scl = 1'b0;
        2'd1:    lines_nxt.sda = 1'b0;
        2'd2:    lines_nxt.scl = 1'b1;
        default: lines_nxt.sda = 1'b1;
      endcase
    end
  end

endmodule

// ===== design/i2cdw_ctrl.sv =====
module i2cdw_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  i2cdw_pkg::action_t  action,
  input  logic [7:0]          payload_byte,
  input  logic                is_data,
  input  logic [7:0]          address_byte,
  output i2cdw_pkg::result_t  result
);

  logic [i2cdw_pkg::StepW-1:0] step_r, step_nxt;
  logic                        active_r, active_nxt;
  logic [7:0]                  payload_r, payload_nxt;
  logic                        is_data_r, is_data_nxt;
  i2cdw_pkg::lines_t           lines_r, lines_nxt;
  i2cdw_pkg::lines_t           lines_step;
  logic [i2cdw_pkg::StepW-1:0] step_cl;
  logic                        done;
  logic                        refused;

  assign step_cl = (step_r > i2cdw_pkg::LastStep) ? i2cdw_pkg::LastStep : step_r;

  i2cdw_step u_step (
    .step         (step_cl),
    .address_byte (address_byte),
    .held_is_data (is_data_r),
    .held_payload (payload_r),
    .lines_cur    (lines_r),
    .lines_nxt    (lines_step)
  );

  always_comb begin
    step_nxt    = step_r;
    active_nxt  = active_r;
    payload_nxt = payload_r;
    is_data_nxt = is_data_r;
    lines_nxt   = lines_r;
    done        = 1'b0;
    refused     = 1'b0;
    if (fire) begin
      if (action == i2cdw_pkg::ACT_SEND) begin
        if (active_r) begin
          refused = 1'b1;
        end else begin
          payload_nxt = payload_byte;
          is_data_nxt = is_data;
          step_nxt    = '0;
          active_nxt  = 1'b1;
        end
      end else if (active_r) begin
        lines_nxt = lines_step;
        if (step_cl >= i2cdw_pkg::LastStep) begin
          active_nxt = 1'b0;
          step_nxt   = '0;
          done       = 1'b1;
        end else begin
          step_nxt = step_cl + 7'd1;
        end
      end
    end
    result.scl     = lines_nxt.scl;
    result.sda     = lines_nxt.sda;
    result.busy    = active_nxt;
    result.done    = done;
    result.refused = refused;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= '0;
      active_r  <= 1'b0;
      payload_r <= '0;
      is_data_r <= 1'b0;
      lines_r   <= '{scl: 1'b1, sda: 1'b1};
    end else begin
      step_r    <= step_nxt;
      active_r  <= active_nxt;
      payload_r <= payload_nxt;
      is_data_r <= is_data_nxt;
      lines_r   <= lines_nxt;
    end
  end

endmodule

// ===== design/i2c_display_write_master_core.sv =====
// Channel | Direction | Handshake              | Payload
// in_     | slave     | in_tvalid / in_tready   | tdata: payload_byte; tuser: action, is_data
// out_    | master    | out_tvalid / out_tready | tdata: scl, sda, busy, done, refused
// cfg_    | slave     | cfg_valid / cfg_ready   | cfg_data: address byte
//
// Each item goes from input transfer to result through the input register and then
// through the pin-step logic into the result register.
// One item is accepted per cycle while the result side keeps taking transfers.
// Reset is synchronous; afterwards both lines read released and the block is idle.
// A stalled result holds the pipeline; the input register still takes one further transfer.
`include "assert_macros.svh"

module i2c_display_write_master_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic [1:0] in_tuser,   // [0] action, [1] is_data
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] scl_level, [1] sda_level, [2] busy_res,
                                 // [3] transfer_done, [4] request_refused, [7:5] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic               in_valid_r;
  logic [7:0]         in_payload_r;
  logic [1:0]         in_user_r;
  logic               out_valid_r, out_valid_nxt;
  i2cdw_pkg::result_t out_res_r;
  i2cdw_pkg::result_t res;
  logic [7:0]         addr_r;
  logic               advance;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  i2cdw_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (advance),
    .action       (i2cdw_pkg::action_t'(in_user_r[0])),
    .payload_byte (in_payload_r),
    .is_data      (in_user_r[1]),
    .address_byte (addr_r),
    .result       (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      addr_r      <= i2cdw_pkg::AddrReset;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        addr_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_payload_r <= in_tdata;
      in_user_r    <= in_tuser;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  `ASSERT_IMPLY(a_refused_busy, clk, rst_n, out_valid_r && out_res_r.refused, out_res_r.busy)
  `ASSERT_IMPLY(a_done_idle, clk, rst_n, out_valid_r && out_res_r.done,
                !out_res_r.busy && out_res_r.scl && out_res_r.sda)
  `ASSERT_IMPLY(a_idle_released, clk, rst_n, out_valid_r && !out_res_r.busy,
                out_res_r.scl && out_res_r.sda)
  `ASSERT_NEXT(a_advance_result, clk, rst_n, advance, out_valid_r)

endmodule

// ===== tb/i2cdw_checker.sv =====
module i2cdw_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] payload_byte
  input  logic [1:0] in_tuser,   // [0] action, [1] is_data
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] scl, [1] sda, [2] busy, [3] done, [4] refused
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         outstanding
);

  localparam int unsigned BitSteps = 24;

  logic [7:0]                  addr_reg;
  logic [i2cdw_pkg::StepW-1:0] step_idx;
  logic                        running;
  logic [7:0]                  latched_byte;
  logic                        latched_data;
  logic                        scl_now;
  logic                        sda_now;
  i2cdw_pkg::result_t          line_results_q[$];
  int                          errs;

  function automatic logic [7:0] byte_on_wire(input int unsigned which);
    if (which == 0) return addr_reg;
    if (which == 1) return latched_data ? i2cdw_pkg::CtrlData : i2cdw_pkg::CtrlCmd;
    return latched_byte;
  endfunction

  function automatic void drive_pins(input int unsigned s);
    int unsigned r;
    logic [7:0] b;
    if (s < i2cdw_pkg::StartSteps) begin
      case (s)
        0: scl_now = 1'b1;
        1: sda_now = 1'b1;
        2: sda_now = 1'b0;
        default: scl_now = 1'b0;
      endcase
    end else if (s < i2cdw_pkg::StopFirst) begin
      r = (s - i2cdw_pkg::StartSteps) % i2cdw_pkg::ByteSteps;
      b = byte_on_wire((s - i2cdw_pkg::StartSteps) / i2cdw_pkg::ByteSteps);
      if (r < BitSteps) begin
        case (r % 3)
          0: sda_now = b[7 - r / 3];
          1: scl_now = 1'b1;
          default: scl_now = 1'b0;
        endcase
      end else if (r == BitSteps) begin
        sda_now = 1'b1;
      end else if (r == BitSteps + 1) begin
        scl_now = 1'b1;
      end else begin
        scl_now = 1'b0;
      end
    end else begin
      case (s - i2cdw_pkg::StopFirst)
        0: scl_now = 1'b0;
        1: sda_now = 1'b0;
        2: scl_now = 1'b1;
        default: sda_now = 1'b1;
      endcase
    end
  endfunction

  function automatic i2cdw_pkg::result_t advance_bus(input i2cdw_pkg::action_t act,
                                                     input logic [7:0] pay,
                                                     input logic dat);
    i2cdw_pkg::result_t res;
    res = '0;
    if (act == i2cdw_pkg::ACT_SEND) begin
      if (running) begin
        res.refused = 1'b1;
      end else begin
        latched_byte = pay;
        latched_data = dat;
        step_idx = '0;
        running = 1'b1;
      end
    end else if (running) begin
      drive_pins(step_idx);
      if (step_idx >= i2cdw_pkg::LastStep) begin
        running = 1'b0;
        step_idx = '0;
        res.done = 1'b1;
      end else begin
        step_idx = step_idx + 1'b1;
      end
    end
    res.scl  = scl_now;
    res.sda  = sda_now;
    res.busy = running;
    return res;
  endfunction

  task automatic compare_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    i2cdw_pkg::result_t seen;
    i2cdw_pkg::result_t want;
    if (!rst_n) begin
      addr_reg     = i2cdw_pkg::AddrReset;
      step_idx     = '0;
      running      = 1'b0;
      latched_byte = '0;
      latched_data = 1'b0;
      scl_now      = 1'b1;
      sda_now      = 1'b1;
      line_results_q.delete();
      errs = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        seen = i2cdw_pkg::result_t'(out_tdata[4:0]);
        if (line_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %05b", $time, out_tdata[4:0]);
          errs++;
        end else begin
          want = line_results_q.pop_front();
          compare_field("scl_level", want.scl, seen.scl);
          compare_field("sda_level", want.sda, seen.sda);
          compare_field("busy_res", want.busy, seen.busy);
          compare_field("transfer_done", want.done, seen.done);
          compare_field("request_refused", want.refused, seen.refused);
        end
        if (out_tdata[7:5] !== 3'b000) begin
          $display("%0t: padding mismatch, expected 000, got %03b", $time, out_tdata[7:5]);
          errs++;
        end
      end
      if (cfg_valid && cfg_ready) addr_reg = cfg_data;
      if (in_tvalid && in_tready) begin
        line_results_q.push_back(advance_bus(i2cdw_pkg::action_t'(in_tuser[0]), in_tdata,
                                             in_tuser[1]));
      end
    end
    fail_count  <= errs;
    outstanding <= line_results_q.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] payload_byte
  logic [1:0] in_tuser;   // [0] action, [1] is_data
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] scl, [1] sda, [2] busy, [3] done, [4] refused
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;
  int         fail_count;
  int         outstanding;

  int   idle_pct;
  int   stall_pct;
  logic hold_request;
  logic hold_served;

  i2c_display_write_master_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  i2cdw_checker bus_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 400000);
    $display("== FAIL ==");
    $finish;
  end

  // The receiver holds off once for a long stretch when asked, otherwise it stalls at random.
  initial begin
    int hold_left;
    out_tready  = 1'b0;
    hold_served = 1'b0;
    hold_left   = 0;
    forever begin
      @(posedge clk);
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input i2cdw_pkg::action_t act, input logic [7:0] pay,
                           input logic dat);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pay;
    in_tuser  <= {dat, act};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_item(i2cdw_pkg::ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  task automatic quiesce();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_addr(input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic one_transaction(input logic [7:0] pay, input logic dat);
    send_item(i2cdw_pkg::ACT_SEND, pay, dat);
    for (int k = 0; k <= i2cdw_pkg::LastStep; k++) begin
      if ($urandom_range(99) < 4) begin
        send_item(i2cdw_pkg::ACT_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      if (k == 12 && $urandom_range(99) < 15) begin
        quiesce();
        write_addr(8'($urandom_range(255)));
      end
      send_item(i2cdw_pkg::ACT_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int idle_tbl[4];
    int stall_tbl[4];
    logic [7:0] addr_tbl[4];
    int n;
    int k;
    idle_tbl  = '{0, 65, 0, 16};
    stall_tbl = '{0, 0, 65, 16};
    addr_tbl  = '{8'hFF, 8'h00, 8'($urandom_range(255)), 8'($urandom_range(255))};
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_request = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // One directed transfer starting at the reset address, with the address rewritten
    // while the address byte is half sent and requests refused at the start and midway.
    send_item(i2cdw_pkg::ACT_TICK, 8'h00, 1'b0);
    send_item(i2cdw_pkg::ACT_SEND, 8'hA5, 1'b0);
    send_item(i2cdw_pkg::ACT_SEND, 8'h00, 1'b1);
    run_ticks(15);
    quiesce();
    write_addr(8'h00);
    run_ticks(15);
    send_item(i2cdw_pkg::ACT_SEND, 8'hFF, 1'b0);
    run_ticks(int'(i2cdw_pkg::LastStep) + 1 - 30);
    send_item(i2cdw_pkg::ACT_TICK, 8'hFF, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      quiesce();
      idle_pct  = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      write_addr(addr_tbl[ph]);
      if (ph == 0) hold_request <= 1'b1;
      n = 0;
      while (n < 90) begin
        if ($urandom_range(99) < 15) quiesce();
        if ($urandom_range(99) < 80) begin
          one_transaction(8'($urandom_range(255)), 1'($urandom_range(1)));
          n += 90;
        end else begin
          k = $urandom_range(5, 1);
          repeat (k) begin
            send_item(i2cdw_pkg::action_t'($urandom_range(1)), 8'($urandom_range(255)),
                      1'($urandom_range(1)));
          end
          n += k;
        end
      end
    end

    quiesce();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
